// ----- rtl/core/rhc_pkg.sv -----
`default_nettype none
package rhc_pkg;

    localparam int unsigned HlsMax   = 255;
    localparam int unsigned HueGrey  = (HlsMax * 2) / 3;
    localparam int unsigned HueGreen = HlsMax / 3;
    localparam int unsigned HueSixth = HlsMax / 6;

    localparam int unsigned NumW  = 17;
    localparam int unsigned DenW  = 9;
    localparam int unsigned QuoW  = 8;
    localparam int unsigned ShrW  = 14;

    localparam logic [1:0] CfgHueLow  = 2'd0;
    localparam logic [1:0] CfgHueHigh = 2'd1;
    localparam logic [1:0] CfgSatMin  = 2'd2;

    typedef enum logic [1:0] {
        T_TOP_RED   = 2'd0,
        T_TOP_GREEN = 2'd1,
        T_TOP_BLUE  = 2'd2
    } t_top;

    // One classified pixel waiting for the dividers.
    typedef struct packed {
        logic [7:0]      lum;
        logic            grey;
        t_top            top;
        logic [NumW-1:0] sat_num;
        logic [DenW-1:0] sat_den;
        logic [ShrW-1:0] num_r;
        logic [ShrW-1:0] num_g;
        logic [ShrW-1:0] num_b;
        logic [7:0]      spread;
    } t_item;

    // Queue handshake between front and back.
    typedef struct packed {
        logic  valid;
        t_item item;
    } t_qhead;

endpackage
`default_nettype wire

// ----- rtl/core/rhc_front.sv -----
`default_nettype none
module rhc_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_ready,
    input  wire logic [23:0]     i_color,
    input  wire logic            i_pop,
    output rhc_pkg::t_qhead      o_head
);

    logic [7:0] w_r, w_g, w_b, w_hi, w_lo, w_spread;
    logic [8:0] w_sum, w_rest, w_div;
    rhc_pkg::t_item w_item;

    rhc_pkg::t_item r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       w_push, w_pop;

    always_comb begin
        w_r = i_color[7:0];
        w_g = i_color[15:8];
        w_b = i_color[23:16];
        w_hi = w_r;
        w_lo = w_r;
        if (w_g > w_hi) w_hi = w_g;
        if (w_b > w_hi) w_hi = w_b;
        if (w_g < w_lo) w_lo = w_g;
        if (w_b < w_lo) w_lo = w_b;
        w_sum    = 9'(w_hi) + 9'(w_lo);
        w_rest   = 9'(2 * rhc_pkg::HlsMax) - w_sum;
        w_spread = w_hi - w_lo;
        w_item.lum  = 8'((10'(w_sum) + 10'd1) >> 1);
        w_item.grey = (w_hi == w_lo);
        if (w_r == w_hi)      w_item.top = rhc_pkg::T_TOP_RED;
        else if (w_g == w_hi) w_item.top = rhc_pkg::T_TOP_GREEN;
        else                  w_item.top = rhc_pkg::T_TOP_BLUE;
        w_div = (w_item.lum <= 8'(rhc_pkg::HlsMax / 2)) ? w_sum : w_rest;
        // A grey pixel never uses the quotient; keep the divisor nonzero.
        if (w_item.grey) w_div = 9'd1;
        w_item.sat_den = w_div;
        w_item.sat_num = ((17'(w_spread) << 8) - 17'(w_spread)) + 17'(w_div >> 1);
        w_item.num_r = 14'(w_hi - w_r) * 14'(rhc_pkg::HueSixth) + 14'(w_spread >> 1);
        w_item.num_g = 14'(w_hi - w_g) * 14'(rhc_pkg::HueSixth) + 14'(w_spread >> 1);
        w_item.num_b = 14'(w_hi - w_b) * 14'(rhc_pkg::HueSixth) + 14'(w_spread >> 1);
        w_item.spread = w_item.grey ? 8'd1 : w_spread;
    end

    assign o_ready = (r_cnt != 2'd2);
    assign w_push  = i_valid && o_ready;
    assign w_pop   = i_pop && (r_cnt != 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) r_q[r_wp] <= w_item;
    end

    assign o_head.valid = (r_cnt != 2'd0);
    assign o_head.item  = r_q[r_rp];

endmodule
`default_nettype wire

// ----- rtl/core/rhc_div.sv -----
`default_nettype none
module rhc_div (
    input  wire logic                          i_clk,
    input  wire logic                          i_en,
    input  wire logic [rhc_pkg::NumW-1:0]      i_num,
    input  wire logic [rhc_pkg::DenW-1:0]      i_den,
    output logic      [rhc_pkg::QuoW-1:0]      o_quo
);

    // One quotient bit per stage, most significant first.
    logic [rhc_pkg::NumW-1:0] r_rem [rhc_pkg::QuoW];
    logic [rhc_pkg::DenW-1:0] r_den [rhc_pkg::QuoW];
    logic [rhc_pkg::QuoW-1:0] r_quo [rhc_pkg::QuoW];
    logic [rhc_pkg::NumW-1:0] n_rem [rhc_pkg::QuoW];
    logic [rhc_pkg::QuoW-1:0] n_quo [rhc_pkg::QuoW];

    always_comb begin
        logic [rhc_pkg::NumW-1:0] v_rem;
        logic [rhc_pkg::NumW-1:0] v_dsh;
        logic [rhc_pkg::QuoW-1:0] v_quo;
        for (int s = 0; s < rhc_pkg::QuoW; s++) begin
            v_rem = (s == 0) ? i_num : r_rem[(s == 0) ? 0 : s - 1];
            v_quo = (s == 0) ? '0    : r_quo[(s == 0) ? 0 : s - 1];
            v_dsh = rhc_pkg::NumW'((s == 0) ? i_den : r_den[(s == 0) ? 0 : s - 1])
                    << (rhc_pkg::QuoW - 1 - s);
            if (v_rem >= v_dsh) begin
                n_rem[s] = v_rem - v_dsh;
                n_quo[s] = v_quo | (rhc_pkg::QuoW'(1) << (rhc_pkg::QuoW - 1 - s));
            end else begin
                n_rem[s] = v_rem;
                n_quo[s] = v_quo;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int s = 0; s < rhc_pkg::QuoW; s++) begin
                r_rem[s] <= n_rem[s];
                r_quo[s] <= n_quo[s];
                r_den[s] <= (s == 0) ? i_den : r_den[(s == 0) ? 0 : s - 1];
            end
        end
    end

    assign o_quo = r_quo[rhc_pkg::QuoW-1];

endmodule
`default_nettype wire

// ----- rtl/core/rhc_back.sv -----
`default_nettype none
module rhc_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire rhc_pkg::t_qhead i_head,
    output logic                 o_pop,
    input  wire logic [7:0]      i_hue_low,
    input  wire logic [7:0]      i_hue_high,
    input  wire logic [7:0]      i_sat_min,
    output logic                 o_valid,
    input  wire logic            i_ready,
    output logic [7:0]           o_hue,
    output logic [7:0]           o_lum,
    output logic [7:0]           o_sat,
    output logic                 o_blue
);

    localparam int unsigned Depth = rhc_pkg::QuoW;

    logic w_en;
    logic [rhc_pkg::QuoW-1:0] w_qs, w_qr, w_qg, w_qb;
    logic          r_v    [Depth];
    logic [7:0]    r_lum  [Depth];
    logic          r_grey [Depth];
    rhc_pkg::t_top r_top  [Depth];

    logic       r_ov;
    logic [7:0] r_hue, r_lum_o, r_sat;
    logic       r_blue;
    logic signed [9:0] w_h;
    logic [7:0] w_hue, w_sat;

    // The whole pipe moves unless the output beat is stalled.
    assign w_en  = !r_ov || i_ready;
    assign o_pop = w_en;

    rhc_div u_div_sat (.i_clk, .i_en(w_en), .i_num(i_head.item.sat_num),
                       .i_den(i_head.item.sat_den), .o_quo(w_qs));
    rhc_div u_div_r (.i_clk, .i_en(w_en), .i_num(17'(i_head.item.num_r)),
                     .i_den(9'(i_head.item.spread)), .o_quo(w_qr));
    rhc_div u_div_g (.i_clk, .i_en(w_en), .i_num(17'(i_head.item.num_g)),
                     .i_den(9'(i_head.item.spread)), .o_quo(w_qg));
    rhc_div u_div_b (.i_clk, .i_en(w_en), .i_num(17'(i_head.item.num_b)),
                     .i_den(9'(i_head.item.spread)), .o_quo(w_qb));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < Depth; s++) r_v[s] <= 1'b0;
        end else if (w_en) begin
            r_v[0] <= i_head.valid;
            for (int s = 1; s < Depth; s++) r_v[s] <= r_v[s-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_lum[0]  <= i_head.item.lum;
            r_grey[0] <= i_head.item.grey;
            r_top[0]  <= i_head.item.top;
            for (int s = 1; s < Depth; s++) begin
                r_lum[s]  <= r_lum[s-1];
                r_grey[s] <= r_grey[s-1];
                r_top[s]  <= r_top[s-1];
            end
        end
    end

    always_comb begin
        unique case (r_top[Depth-1])
            rhc_pkg::T_TOP_RED:   w_h = 10'(w_qb) - 10'(w_qg);
            rhc_pkg::T_TOP_GREEN: w_h = 10'(rhc_pkg::HueGreen) + 10'(w_qr) - 10'(w_qb);
            default:              w_h = 10'(rhc_pkg::HueGrey) + 10'(w_qg) - 10'(w_qr);
        endcase
        if (w_h < 0) w_h = w_h + 10'(rhc_pkg::HlsMax);
        w_hue = r_grey[Depth-1] ? 8'(rhc_pkg::HueGrey) : w_h[7:0];
        w_sat = r_grey[Depth-1] ? 8'd0 : w_qs;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ov <= 1'b0;
        else if (w_en) r_ov <= r_v[Depth-1];
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_hue   <= w_hue;
            r_lum_o <= r_lum[Depth-1];
            r_sat   <= w_sat;
            r_blue  <= (w_hue >= i_hue_low) && (w_hue <= i_hue_high) && (w_sat > i_sat_min);
        end
    end

    assign o_valid = r_ov;
    assign o_hue   = r_hue;
    assign o_lum   = r_lum_o;
    assign o_sat   = r_sat;
    assign o_blue  = r_blue;

endmodule
`default_nettype wire

// ----- rtl/core/rgb_to_hls_converter_top.sv -----
// Channel   Direction  Handshake                    Payload
// s         in         i_s_tvalid / o_s_tready      i_s_tdata: color[23:0]
// m         out        o_m_tvalid / i_m_tready      o_m_tdata: hue, lightness, saturation, is_blue
// cfg       in         i_cfg_we                     i_cfg_addr, i_cfg_wdata
//
// One pixel per clock sustained while the output beat is not stalled; an accepted pixel passes
// through the two-entry queue, the bit-per-stage dividers and the output register, in that order.
// Reset is synchronous and active low and restores the blue window defaults.
// A stalled output beat freezes the divider pipe; the queue keeps taking pixels until full.
`default_nettype none
module rgb_to_hls_converter_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [23:0] i_s_tdata,   // color[23:0]
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [31:0]      o_m_tdata,   // hue[7:0], lightness[15:8], saturation[23:16],
                                          // is_blue[24], zeros[31:25]
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_addr,
    input  wire logic [7:0]  i_cfg_wdata
);

    logic [7:0] r_hue_low, r_hue_high, r_sat_min;
    rhc_pkg::t_qhead w_head;
    logic w_pop;
    logic [7:0] w_hue, w_lum, w_sat;
    logic w_blue;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hue_low  <= 8'd145;
            r_hue_high <= 8'd175;
            r_sat_min  <= 8'd100;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                rhc_pkg::CfgHueLow:  r_hue_low  <= i_cfg_wdata;
                rhc_pkg::CfgHueHigh: r_hue_high <= i_cfg_wdata;
                rhc_pkg::CfgSatMin:  r_sat_min  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    rhc_front u_front (
        .i_clk, .i_rst_n,
        .i_valid(i_s_tvalid), .o_ready(o_s_tready), .i_color(i_s_tdata),
        .i_pop(w_pop), .o_head(w_head)
    );

    rhc_back u_back (
        .i_clk, .i_rst_n,
        .i_head(w_head), .o_pop(w_pop),
        .i_hue_low(r_hue_low), .i_hue_high(r_hue_high), .i_sat_min(r_sat_min),
        .o_valid(o_m_tvalid), .i_ready(i_m_tready),
        .o_hue(w_hue), .o_lum(w_lum), .o_sat(w_sat), .o_blue(w_blue)
    );

    assign o_m_tdata = {7'd0, w_blue, w_sat, w_lum, w_hue};

endmodule
`default_nettype wire

// ----- rtl/core/rhc_checker.sv -----
`default_nettype none
module rhc_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_m_tvalid,
    input wire logic        i_m_tready,
    input wire logic [31:0] o_m_tdata
);

    a_reset_idle: assert property (@(posedge i_clk) !i_rst_n |=> !o_m_tvalid)
        else $error("output valid right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("stalled output beat changed");

    // Zero saturation only comes from a grey pixel.
    a_grey_hue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[23:16] == 8'd0 |-> o_m_tdata[7:0] == 8'd170)
        else $error("zero saturation without grey hue");

    a_hue_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[7:0] != 8'd255 && o_m_tdata[31:25] == 7'd0)
        else $error("hue out of range or padding set");

    a_blue_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[24] |-> o_m_tdata[23:16] != 8'd0)
        else $error("blue flag with zero saturation");

endmodule

bind rgb_to_hls_converter_top rhc_checker u_rhc_checker (
    .i_clk, .i_rst_n, .o_m_tvalid, .i_m_tready, .o_m_tdata
);
`default_nettype wire

// ----- tb/hls_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
module hls_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    input  wire logic        i_s_tready,
    input  wire logic [23:0] i_s_tdata,
    input  wire logic        i_m_tvalid,
    input  wire logic        i_m_tready,
    input  wire logic [31:0] i_m_tdata,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_addr,
    input  wire logic [7:0]  i_cfg_wdata,
    output int               o_fail_count,
    output int               o_pending
);

    typedef struct packed {
        logic       is_blue;
        logic [7:0] sat;
        logic [7:0] lum;
        logic [7:0] hue;
    } t_hls;

    logic [7:0] win_low, win_high, sat_floor;
    t_hls       hls_q[$];

    function automatic int share(int top, int chan, int spread);
        return ((top - chan) * int'(rhc_pkg::HueSixth) + spread / 2) / spread;
    endfunction

    function automatic t_hls convert(logic [23:0] px);
        int r, g, b, hi, lo, sum, lum, sat, spread, hue, rest;
        t_hls o;
        r = px[7:0]; g = px[15:8]; b = px[23:16];
        hi = r; lo = r;
        if (g > hi) hi = g;
        if (b > hi) hi = b;
        if (g < lo) lo = g;
        if (b < lo) lo = b;
        sum = hi + lo;
        lum = (sum * 255 + 255) / 510;
        if (hi == lo) begin
            sat = 0;
            hue = rhc_pkg::HueGrey;
        end else begin
            spread = hi - lo;
            rest = (lum <= 127) ? sum : 510 - sum;
            sat = (spread * 255 + rest / 2) / rest;
            if (r == hi) hue = share(hi, b, spread) - share(hi, g, spread);
            else if (g == hi)
                hue = 85 + share(hi, r, spread) - share(hi, b, spread);
            else hue = 170 + share(hi, g, spread) - share(hi, r, spread);
            if (hue < 0) hue += 255;
            if (hue > 255) hue -= 255;
        end
        o.hue = hue[7:0];
        o.lum = lum[7:0];
        o.sat = sat[7:0];
        o.is_blue = (o.hue >= win_low) && (o.hue <= win_high) && (o.sat > sat_floor);
        return o;
    endfunction

    assign o_pending = hls_q.size();

    always_ff @(posedge i_clk) begin
        t_hls exp_v, act;
        if (!i_rst_n) begin
            win_low <= 8'd145; win_high <= 8'd175; sat_floor <= 8'd100;
            o_fail_count <= 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    rhc_pkg::CfgHueLow:  win_low <= i_cfg_wdata;
                    rhc_pkg::CfgHueHigh: win_high <= i_cfg_wdata;
                    rhc_pkg::CfgSatMin:  sat_floor <= i_cfg_wdata;
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready) hls_q.push_back(convert(i_s_tdata));
            if (i_m_tvalid && i_m_tready) begin
                act = i_m_tdata[24:0];
                if (hls_q.size() == 0) begin
                    $error("unexpected beat %h", i_m_tdata);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_v = hls_q.pop_front();
                    if (act != exp_v || i_m_tdata[31:25] != 0) begin
                        if (act.hue != exp_v.hue)
                            $error("hue exp %0d got %0d", exp_v.hue, act.hue);
                        if (act.lum != exp_v.lum)
                            $error("lightness exp %0d got %0d", exp_v.lum, act.lum);
                        if (act.sat != exp_v.sat)
                            $error("saturation exp %0d got %0d", exp_v.sat, act.sat);
                        if (act.is_blue != exp_v.is_blue)
                            $error("is_blue exp %0d got %0d", exp_v.is_blue, act.is_blue);
                        if (i_m_tdata[31:25] != 0)
                            $error("pad exp 0 got %0h", i_m_tdata[31:25]);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end
endmodule
`default_nettype wire

// ----- tb/tb_rgb_to_hls_converter_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
module tb_rgb_to_hls_converter_top;

    logic        i_clk, i_rst_n;
    logic        i_s_tvalid, o_s_tready;
    logic [23:0] i_s_tdata;
    logic        o_m_tvalid, i_m_tready;
    logic [31:0] o_m_tdata;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_addr;
    logic [7:0]  i_cfg_wdata;
    int          fail_count, pending, cycles;
    int          rdy_wait;

    rgb_to_hls_converter_top u_top (.*);

    hls_checker u_chk (
        .i_clk, .i_rst_n, .i_s_tvalid, .i_s_tready(o_s_tready), .i_s_tdata,
        .i_m_tvalid(o_m_tvalid), .i_m_tready, .i_m_tdata(o_m_tdata),
        .i_cfg_we, .i_cfg_addr, .i_cfg_wdata,
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Receiver stalls for random stretches, mostly short and now and then long.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
            rdy_wait   <= 0;
        end else if (rdy_wait > 0) begin
            i_m_tready <= 1'b0;
            rdy_wait   <= rdy_wait - 1;
        end else begin
            i_m_tready <= 1'b1;
            rdy_wait   <= gap_len();
        end
    end

    always @(posedge i_clk) cycles <= cycles + 1;

    always @(posedge i_clk) begin
        if (cycles > 200000) begin
            $display("** rgb_to_hls_converter_top: FAILED **");
            $finish;
        end
    end

    // Valid stays high into the next beat when no gap follows.
    task automatic send_pixel(logic [23:0] px, bit no_gap);
        int g;
        g = no_gap ? 0 : gap_len();
        if (g > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= px;
        do @(posedge i_clk); while (!o_s_tready);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [7:0] val);
        i_cfg_we <= 1'b1; i_cfg_addr <= idx; i_cfg_wdata <= val;
        @(posedge i_clk);
    endtask

    task automatic drain();
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    function automatic logic [23:0] rand_pixel();
        logic [7:0] c[3];
        int k;
        k = $urandom_range(0, 9);
        foreach (c[j]) c[j] = 8'($urandom);
        if (k == 0) c[1] = c[0];
        if (k <= 1) c[2] = c[0];
        if (k == 2) c[1] = c[2];
        if (k == 3) begin
            c[1] = c[0]; c[2] = c[0] - 8'($urandom_range(0, 3));
        end
        if (k == 4) c[$urandom_range(0, 2)] = 8'hFF;
        if (k == 5) c[$urandom_range(0, 2)] = 8'h00;
        return {c[2], c[1], c[0]};
    endfunction

    logic [23:0] directed[] = '{
        24'h000000, 24'hFFFFFF, 24'h808080, 24'h0000FF, 24'h00FF00, 24'hFF0000,
        24'hFFFF00, 24'hFF00FF, 24'h00FFFF, 24'hFFFFFE, 24'h000001, 24'h7F7F80,
        24'hC02020, 24'h802010, 24'h102080, 24'h0100FF, 24'hFF0001, 24'h55AA55,
        24'hAA5555, 24'h123456, 24'hFEDCBA, 24'hE00000, 24'h0000E0
    };

    initial begin
        logic [7:0] lo_v, hi_v, s_v;
        cycles = 0;
        i_rst_n = 1'b0; i_s_tvalid = 1'b0; i_s_tdata = '0;
        i_cfg_we = 1'b0; i_cfg_addr = '0; i_cfg_wdata = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[j]) send_pixel(directed[j], 1'b0);
        i_s_tvalid <= 1'b0;
        drain();

        // Unused index must leave the window alone.
        write_reg(2'd3, 8'h00);
        for (int ph = 0; ph < 9; ph++) begin
            case (ph)
                0: begin lo_v = 0;   hi_v = 255; s_v = 0;   end
                1: begin lo_v = 255; hi_v = 255; s_v = 255; end
                2: begin lo_v = 200; hi_v = 100; s_v = 10;  end   // empty window
                3: begin lo_v = 0;   hi_v = 0;   s_v = 254; end
                default: begin
                    lo_v = 8'($urandom); hi_v = lo_v + 8'($urandom_range(0, 80));
                    if (hi_v < lo_v) hi_v = 255;
                    s_v = 8'($urandom);
                end
            endcase
            if (ph != 8) begin
                write_reg(rhc_pkg::CfgHueLow, lo_v);
                write_reg(rhc_pkg::CfgHueHigh, hi_v);
                write_reg(rhc_pkg::CfgSatMin, s_v);
                i_cfg_we <= 1'b0;
            end
            for (int n = 0; n < 150; n++) send_pixel(rand_pixel(), (ph % 3) == 1);
            i_s_tvalid <= 1'b0;
            drain();
        end

        if (fail_count == 0) begin
            $display("** rgb_to_hls_converter_top: PASSED **");
        end else begin
            $display("** rgb_to_hls_converter_top: FAILED **");
        end
        $finish;
    end
endmodule
`default_nettype wire

// ----- rgb_to_hls_converter_top.f -----
rtl/core/rhc_pkg.sv
rtl/core/rhc_front.sv
rtl/core/rhc_div.sv
rtl/core/rhc_back.sv
rtl/core/rgb_to_hls_converter_top.sv
rtl/core/rhc_checker.sv
tb/hls_checker.sv
tb/tb_rgb_to_hls_converter_top.sv
